// ===== sv/range_window_average_hysteresis_top_defines.svh =====
// assertion macros shared by the range window average hysteresis rtl
`ifndef RANGE_WINDOW_AVERAGE_HYSTERESIS_TOP_DEFINES_SVH
`define RANGE_WINDOW_AVERAGE_HYSTERESIS_TOP_DEFINES_SVH

// same-cycle implication
`define RWAH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rwah assertion failed");

// next-cycle implication
`define RWAH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rwah assertion failed");

`endif

// ===== sv/rwah_pkg.sv =====
// shared widths for the range window average hysteresis block
package rwah_pkg;
	localparam int DIST_W  = 16;
	localparam int ENTRY_W = DIST_W + 1;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 3;
endpackage

// ===== sv/rwah_win_mem.sv =====
// window sample memory, one write port and one registered read port
module rwah_win_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [rwah_pkg::ENTRY_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [rwah_pkg::ENTRY_W-1:0] rd_data
);
	import rwah_pkg::*;

	logic [ENTRY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== sv/rwah_div.sv =====
// restoring divider, one quotient bit per cycle
module rwah_div #(
	parameter int NUM_W = 19,
	parameter int DEN_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);
	import rwah_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits back in DEN_W bits
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/range_window_average_hysteresis_top.sv =====
// Range window average with hysteresis. Each input item (s_tdata = distance,
// s_tuser = no-echo flag) is written into a ring window of WINDOW entries; once
// the window has filled, each item gives one result: no-echo when at least half
// the window is no-echo, else the average of the finite entries, which replaces
// the held output only when it moves by more than hysteresis_delta (or the held
// output was no-echo). An item that gives a result passes through the accept, a
// walk of the window memory one entry per cycle through its registered read port,
// a restoring divider that yields one quotient bit per cycle (skipped when the
// result is no-echo), and the posting of the result; a result still held by
// m_tready adds its stall. s_tready is low while an item is in work. Items that
// only fill the window give no result.
module range_window_average_hysteresis_top #(
	parameter int WINDOW = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// apb configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rwah_pkg::APB_AW-1:0] paddr,
	input  logic [rwah_pkg::APB_DW-1:0] pwdata,
	output logic [rwah_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	// input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [rwah_pkg::DIST_W-1:0] s_tdata,   // [15:0] range_sample
	input  logic                        s_tuser,   // [0] no_echo
	// output stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [rwah_pkg::DIST_W-1:0] m_tdata,   // [15:0] filtered_range
	output logic                        m_tuser    // [0] out_of_range
);
	import rwah_pkg::*;

	`include "range_window_average_hysteresis_top_defines.svh"

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = DIST_W + CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic               full_q;
	logic [DIST_W-1:0]  held_q;
	logic               held_inf_q;
	logic [DIST_W-1:0]  delta_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               rd_vld_s1;
	logic [CNT_W-1:0]   infs_q;
	logic [SUM_W-1:0]   sum_q;
	logic               res_inf_q;
	logic [DIST_W-1:0]  avg_q;
	logic               m_tvalid_q;
	logic [DIST_W-1:0]  m_tdata_q;
	logic               m_tuser_q;

	logic               in_acc;
	logic               cfg_wr;
	logic               last_slot;
	logic [ENTRY_W-1:0] wr_entry;
	logic               rd_issue;
	logic [ENTRY_W-1:0] rd_entry;
	logic               walk_end;
	logic               half_inf;
	logic               div_start;
	logic               div_busy;
	logic               div_done;
	logic [SUM_W-1:0]   div_quo;
	logic [CNT_W-1:0]   finite_cnt;
	logic               out_free;
	logic [DIST_W-1:0]  abs_diff;
	logic               take_avg;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {{(APB_DW - DIST_W){1'b0}}, delta_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q <= '0;
		end else if (cfg_wr) begin
			delta_q <= pwdata[DIST_W-1:0];
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign last_slot = (wr_ptr_q == PTR_W'(WINDOW - 1));
	// no-echo entries store a zero distance
	assign wr_entry  = s_tuser ? {1'b1, {DIST_W{1'b0}}} : {1'b0, s_tdata};

	assign rd_issue   = (state_q == ST_WALK) && (rd_cnt_q != CNT_W'(WINDOW));
	assign walk_end   = (state_q == ST_WALK) && (rd_cnt_q == CNT_W'(WINDOW)) && !rd_vld_s1;
	assign half_inf   = {infs_q, 1'b0} >= (CNT_W + 1)'(WINDOW);
	assign finite_cnt = CNT_W'(WINDOW) - infs_q;
	assign div_start  = walk_end && !half_inf;

	rwah_win_mem #(
		.DEPTH (WINDOW),
		.AW    (PTR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_addr (wr_ptr_q),
		.wr_data (wr_entry),
		.rd_en   (rd_issue),
		.rd_addr (rd_cnt_q[PTR_W-1:0]),
		.rd_data (rd_entry)
	);

	rwah_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (finite_cnt),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign abs_diff = (avg_q > held_q) ? (avg_q - held_q) : (held_q - avg_q);
	assign take_avg = held_inf_q || (abs_diff > delta_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_ptr_q   <= '0;
			full_q     <= 1'b0;
			held_q     <= '0;
			held_inf_q <= 1'b1;
			rd_cnt_q   <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						wr_ptr_q <= last_slot ? '0 : wr_ptr_q + 1'b1;
						if (last_slot) begin
							full_q <= 1'b1;
						end
						rd_cnt_q <= '0;
						if (full_q || last_slot) begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (rd_issue) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (walk_end) begin
						state_q <= half_inf ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
						if (res_inf_q) begin
							held_inf_q <= 1'b1;
							held_q     <= '0;
						end else if (take_avg) begin
							held_inf_q <= 1'b0;
							held_q     <= avg_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window sums and result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q  <= '0;
			infs_q <= '0;
		end else if (rd_vld_s1) begin
			if (rd_entry[DIST_W]) begin
				infs_q <= infs_q + 1'b1;
			end else begin
				sum_q <= sum_q + SUM_W'(rd_entry[DIST_W-1:0]);
			end
		end
		if (walk_end) begin
			res_inf_q <= half_inf;
		end
		if (div_done) begin
			avg_q <= div_quo[DIST_W-1:0];
		end
		if ((state_q == ST_DONE) && out_free) begin
			if (res_inf_q) begin
				m_tdata_q <= '0;
				m_tuser_q <= 1'b1;
			end else if (take_avg) begin
				m_tdata_q <= avg_q;
				m_tuser_q <= 1'b0;
			end else begin
				m_tdata_q <= held_inf_q ? '0 : held_q;
				m_tuser_q <= held_inf_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`RWAH_ASSERT_NOW(a_ready_not_dividing, clk, arst_n, s_tready, !div_busy)
	`RWAH_ASSERT_NOW(a_result_needs_full, clk, arst_n, state_q == ST_DONE, full_q)
	`RWAH_ASSERT_NOW(a_no_echo_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	`RWAH_ASSERT_NEXT(a_done_from_div, clk, arst_n, div_done, state_q == ST_DONE)
endmodule
